// ===== hdl/ppi_pkg.sv =====
// ppi_pkg: shared types and constants for the parallel port interface
// used by ppi_exec and parallel_port_interface; no dependencies
`timescale 1ns / 1ps

package ppi_pkg;

  // access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // port select codes
  localparam logic [1:0] PORT_A    = 2'd0;
  localparam logic [1:0] PORT_B    = 2'd1;
  localparam logic [1:0] PORT_C    = 2'd2;
  localparam logic [1:0] PORT_CTRL = 2'd3;

  // control word after reset: all ports input
  localparam logic [7:0] CW_RESET = 8'h9b;

  // control word bit positions
  localparam int CW_C_LO_IN  = 0;
  localparam int CW_B_IN     = 1;
  localparam int CW_B_MODE   = 2;
  localparam int CW_C_HI_IN  = 3;
  localparam int CW_A_IN     = 4;
  localparam int CW_A_MODE_L = 5;
  localparam int CW_A_MODE_H = 6;
  localparam int CW_MODE_SET = 7;

  // value read from a port in a handshake mode
  localparam logic [7:0] HS_READ = 8'hff;

  typedef struct packed {
    logic       opcode;
    logic [1:0] port;
    logic [7:0] write_data;
    logic [7:0] pins_a_in;
    logic [7:0] pins_b_in;
    logic [3:0] pins_c_low_in;
    logic [3:0] pins_c_high_in;
  } ppi_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] drive_a;
    logic       drive_a_strobe;
    logic [7:0] drive_b;
    logic       drive_b_strobe;
    logic [3:0] drive_c_low;
    logic       drive_c_low_strobe;
    logic [3:0] drive_c_high;
    logic       drive_c_high_strobe;
  } ppi_result_t;

endpackage

// ===== hdl/ppi_exec.sv =====
// ppi_exec: port latches, control word and the access decode for one bus access
// depends on ppi_pkg
`timescale 1ns / 1ps

module ppi_exec (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  ppi_pkg::ppi_item_t   item,
  output ppi_pkg::ppi_result_t result
);

  logic [7:0] latch_a, latch_a_next;
  logic [7:0] latch_b, latch_b_next;
  logic [7:0] latch_c, latch_c_next;
  logic [7:0] control_word, control_word_next;

  logic       wr_a, wr_b, wr_c, mode_set, bit_op;
  logic [7:0] cw_eff;
  logic [7:0] bit_mask;
  logic [7:0] bit_val;
  logic       put_a, put_b, put_c;
  logic [7:0] rd;

  always_comb begin
    wr_a     = (item.opcode == ppi_pkg::OP_WRITE) && (item.port == ppi_pkg::PORT_A);
    wr_b     = (item.opcode == ppi_pkg::OP_WRITE) && (item.port == ppi_pkg::PORT_B);
    wr_c     = (item.opcode == ppi_pkg::OP_WRITE) && (item.port == ppi_pkg::PORT_C);
    mode_set = (item.opcode == ppi_pkg::OP_WRITE) && (item.port == ppi_pkg::PORT_CTRL)
               && item.write_data[ppi_pkg::CW_MODE_SET];
    bit_op   = (item.opcode == ppi_pkg::OP_WRITE) && (item.port == ppi_pkg::PORT_CTRL)
               && !item.write_data[ppi_pkg::CW_MODE_SET];

    cw_eff   = mode_set ? item.write_data : control_word;
    bit_mask = 8'd1 << item.write_data[3:1];
    bit_val  = item.write_data[0] ? (latch_c | bit_mask) : (latch_c & ~bit_mask);

    put_a = wr_a || mode_set;
    put_b = wr_b || mode_set;
    put_c = wr_c || mode_set || bit_op;

    latch_a_next      = wr_a ? item.write_data : latch_a;
    latch_b_next      = wr_b ? item.write_data : latch_b;
    latch_c_next      = wr_c ? item.write_data : (bit_op ? bit_val : latch_c);
    control_word_next = cw_eff;

    // read path sees the control word as it was before this access
    rd = '0;
    if (item.opcode == ppi_pkg::OP_READ) begin
      case (item.port)
        ppi_pkg::PORT_A: begin
          if (control_word[ppi_pkg::CW_A_MODE_H] || control_word[ppi_pkg::CW_A_MODE_L])
            rd = ppi_pkg::HS_READ;
          else
            rd = control_word[ppi_pkg::CW_A_IN] ? item.pins_a_in : latch_a;
        end
        ppi_pkg::PORT_B: begin
          if (control_word[ppi_pkg::CW_B_MODE])
            rd = ppi_pkg::HS_READ;
          else
            rd = control_word[ppi_pkg::CW_B_IN] ? item.pins_b_in : latch_b;
        end
        ppi_pkg::PORT_C: begin
          rd = {control_word[ppi_pkg::CW_C_HI_IN] ? item.pins_c_high_in : latch_c[7:4],
                control_word[ppi_pkg::CW_C_LO_IN] ? item.pins_c_low_in  : latch_c[3:0]};
        end
        default: rd = control_word;
      endcase
    end

    result.read_data           = rd;
    result.drive_a_strobe      = put_a && !cw_eff[ppi_pkg::CW_A_IN];
    result.drive_a             = result.drive_a_strobe ? latch_a_next : '0;
    result.drive_b_strobe      = put_b && !cw_eff[ppi_pkg::CW_B_IN];
    result.drive_b             = result.drive_b_strobe ? latch_b_next : '0;
    result.drive_c_low_strobe  = put_c && !cw_eff[ppi_pkg::CW_C_LO_IN];
    result.drive_c_low         = result.drive_c_low_strobe ? latch_c_next[3:0] : '0;
    result.drive_c_high_strobe = put_c && !cw_eff[ppi_pkg::CW_C_HI_IN];
    result.drive_c_high        = result.drive_c_high_strobe ? latch_c_next[7:4] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latch_a      <= '0;
      latch_b      <= '0;
      latch_c      <= '0;
      control_word <= ppi_pkg::CW_RESET;
    end else if (fire) begin
      latch_a      <= latch_a_next;
      latch_b      <= latch_b_next;
      latch_c      <= latch_c_next;
      control_word <= control_word_next;
    end
  end

endmodule

// ===== hdl/parallel_port_interface.sv =====
// parallel_port_interface: top level, input register, result register and handshakes
// depends on ppi_pkg and ppi_exec
`timescale 1ns / 1ps

// three-port parallel interface with a control word, one bus access per transfer
// input channel: in_valid / in_ready carry opcode, port, write_data and the
// sampled pin levels of ports a, b and the two c nibbles
// output channel: out_valid / out_ready carry read_data and the drive values
// with their strobes; exactly one result transfer per input transfer
// path: each input transfer fills the input register, then is decoded against
// the latches into the result register, which offers it on out_valid
// throughput: one access per cycle while the receiver does not stall, set by
// the single decode stage that updates the latches and the control word as
// each access leaves the input register
// a stalled receiver holds the result register; the input register still
// takes one more transfer, after which in_ready drops until out_ready returns
// reset clears both valid flags, the latches to zero and the control word to
// 0x9b (all ports input, mode 0)

module parallel_port_interface (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       opcode,
  input  logic [1:0] port,
  input  logic [7:0] write_data,
  input  logic [7:0] pins_a_in,
  input  logic [7:0] pins_b_in,
  input  logic [3:0] pins_c_low_in,
  input  logic [3:0] pins_c_high_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic [7:0] drive_a,
  output logic       drive_a_strobe,
  output logic [7:0] drive_b,
  output logic       drive_b_strobe,
  output logic [3:0] drive_c_low,
  output logic       drive_c_low_strobe,
  output logic [3:0] drive_c_high,
  output logic       drive_c_high_strobe
);

  // input register
  logic                 s1_valid;
  ppi_pkg::ppi_item_t   s1_item;
  // result register
  ppi_pkg::ppi_result_t res;
  ppi_pkg::ppi_result_t res_next;

  logic s1_adv;   // result register can take the item in the input register
  logic s1_fire;  // item leaves the input register this cycle

  assign s1_adv   = !out_valid || out_ready;
  assign s1_fire  = s1_valid && s1_adv;
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.opcode         <= opcode;
      s1_item.port           <= port;
      s1_item.write_data     <= write_data;
      s1_item.pins_a_in      <= pins_a_in;
      s1_item.pins_b_in      <= pins_b_in;
      s1_item.pins_c_low_in  <= pins_c_low_in;
      s1_item.pins_c_high_in <= pins_c_high_in;
    end
  end

  ppi_exec u_exec (
    .clk    (clk),
    .rst    (rst),
    .fire   (s1_fire),
    .item   (s1_item),
    .result (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res <= res_next;
    end
  end

  assign read_data           = res.read_data;
  assign drive_a             = res.drive_a;
  assign drive_a_strobe      = res.drive_a_strobe;
  assign drive_b             = res.drive_b;
  assign drive_b_strobe      = res.drive_b_strobe;
  assign drive_c_low         = res.drive_c_low;
  assign drive_c_low_strobe  = res.drive_c_low_strobe;
  assign drive_c_high        = res.drive_c_high;
  assign drive_c_high_strobe = res.drive_c_high_strobe;

`ifndef SYNTH
  // a held item in the input register is never dropped while stalled
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid)
    else $error("input register lost an item while stalled");

  // an item leaving the input register shows up as a result
  a_s1_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_valid)
    else $error("item left input register without a result");

  // back-pressure only when both registers are full and the receiver stalls
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("in_ready low without a full stalled pipeline");

  // undriven ports a and b report zero
  a_idle_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid && !drive_a_strobe && !drive_b_strobe |-> drive_a == 8'd0 && drive_b == 8'd0)
    else $error("drive value present without strobe");
`endif

endmodule
